// File: sv/sll_pkg.sv
// Shared types and constants for the static linked list insert block.
package sll_pkg;

  localparam int SLOTS_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 16;
  localparam int POS_BITS       = 10;
  localparam int IN_VALUE_BITS  = 16;
  localparam int FIELD_BITS     = 10;
  localparam int LEN_BITS       = 11;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [FIELD_BITS-1:0]   slot;
    logic [FIELD_BITS-1:0]   pred;
  } result_t;

endpackage

// File: sv/sll_link_ram.sv
// Single write port, single registered read port RAM holding the link array.
module sll_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/sll_ctrl.sv
// Insert sequencer: clear pass, free slot pop, link walk and splice.
module sll_ctrl #(
  parameter int SLOTS      = sll_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = sll_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sll_pkg::POS_BITS-1:0]       position,
  input  logic [sll_pkg::IN_VALUE_BITS-1:0]  value,
  output logic                               res_valid,
  input  logic                               res_ready,
  output sll_pkg::result_t                   res
);

  import sll_pkg::*;

  localparam int LINK_BITS = $clog2(SLOTS);
  localparam logic [LINK_BITS-1:0] HEAD_SLOT = LINK_BITS'(SLOTS - 1);
  localparam logic [LINK_BITS-1:0] TAIL_FREE = LINK_BITS'(SLOTS - 2);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_WALK,
    S_SPLICE,
    S_DONE
  } state_t;

  state_t                 state;
  logic [LINK_BITS-1:0]   clr_idx;
  logic [LINK_BITS-1:0]   free_head;
  logic [LINK_BITS-1:0]   fresh;
  logic [LINK_BITS-1:0]   k;
  logic [POS_BITS-1:0]    remaining;
  logic [LEN_BITS-1:0]    len;

  logic                   accept;
  logic                   bad_pos;
  logic [LEN_BITS:0]      len_plus;

  logic                   ram_we;
  logic [LINK_BITS-1:0]   ram_waddr;
  logic [LINK_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [LINK_BITS-1:0]   ram_raddr;
  logic [LINK_BITS-1:0]   ram_rdata;

  logic [VALUE_BITS-1:0]  node_value [SLOTS];

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign res_valid = (state == S_DONE);
  assign len_plus  = (LEN_BITS + 1)'(len) + (LEN_BITS + 1)'(1);
  assign bad_pos   = (position == '0) || ((LEN_BITS + 1)'(position) > len_plus);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = free_head;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = (clr_idx == TAIL_FREE || clr_idx == HEAD_SLOT) ? '0 :
                    LINK_BITS'(clr_idx + LINK_BITS'(1));
      end
      S_IDLE: begin
        ram_re    = accept;
        ram_raddr = free_head;
      end
      S_POP: begin
        ram_re    = 1'b1;
        ram_raddr = HEAD_SLOT;
      end
      S_WALK: begin
        if (remaining == '0) begin
          ram_we    = 1'b1;
          ram_waddr = fresh;
          ram_wdata = ram_rdata;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ram_rdata;
        end
      end
      S_SPLICE: begin
        ram_we    = 1'b1;
        ram_waddr = k;
        ram_wdata = fresh;
      end
      default: begin
        ram_we = 1'b0;
        ram_re = 1'b0;
      end
    endcase
  end

  sll_link_ram #(
    .DEPTH (SLOTS),
    .WIDTH (LINK_BITS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept && !bad_pos && free_head != '0) begin
      node_value[free_head] <= VALUE_BITS'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      free_head <= LINK_BITS'(1);
      len       <= '0;
      fresh     <= '0;
      k         <= '0;
      remaining <= '0;
      res       <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= LINK_BITS'(clr_idx + LINK_BITS'(1));
          if (clr_idx == HEAD_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (bad_pos) begin
              res   <= '{status: ST_RANGE, slot: '0, pred: '0};
              state <= S_DONE;
            end else if (free_head == '0) begin
              res   <= '{status: ST_FULL, slot: '0, pred: '0};
              state <= S_DONE;
            end else begin
              fresh     <= free_head;
              remaining <= POS_BITS'(position - POS_BITS'(1));
              state     <= S_POP;
            end
          end
        end
        S_POP: begin
          free_head <= ram_rdata;
          k         <= HEAD_SLOT;
          state     <= S_WALK;
        end
        S_WALK: begin
          if (remaining == '0) begin
            state <= S_SPLICE;
          end else begin
            k         <= ram_rdata;
            remaining <= POS_BITS'(remaining - POS_BITS'(1));
          end
        end
        S_SPLICE: begin
          len   <= LEN_BITS'(len + LEN_BITS'(1));
          res   <= '{status: ST_OK, slot: FIELD_BITS'(fresh), pred: FIELD_BITS'(k)};
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |-> res.slot == '0 && res.pred == '0)
    else $error("rejected insert reports nonzero slot or predecessor");

  a_free_not_head: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |-> free_head != HEAD_SLOT)
    else $error("data head slot entered the free chain");

  a_walk_in_list: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && remaining != '0 |-> ram_rdata != '0)
    else $error("walk ran off the end of the data chain");

  a_fresh_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLICE |-> fresh != '0 && fresh != HEAD_SLOT && fresh != k)
    else $error("allocated slot is not a free slot");
`endif

endmodule

// File: sv/static_linked_list_insert_top.sv
// Top level of the static linked list insert block with output register.
//
// Input channel: in_valid/in_stall carry position and value; a beat is taken
// when in_valid is high and in_stall low. Output channel: out_valid/out_stall
// carry status, slot and predecessor, one beat per input beat, in order.
// After reset the link RAM is initialized by a clearing pass over all SLOTS
// entries (one entry per cycle); in_stall stays high until it finishes.
// An insert before position p passes through S_POP, S_WALK and S_SPLICE into
// the result register and then the output register: the walk follows one link
// per cycle through the single registered read port of the link RAM. A rejected
// insert (bad position or no free slot) goes from acceptance straight into the
// result register and then the output register. One insert is in flight at a
// time; the next input beat is taken once the current result has moved to the
// output register.
// While out_stall is high the output beat holds; a finished result then waits
// inside the sequencer and no new input is taken until it moves on.
// Status codes: 0 inserted, 1 position out of range, 2 no free slot.
module static_linked_list_insert_top #(
  parameter int SLOTS      = sll_pkg::SLOTS_DEF,
  parameter int VALUE_BITS = sll_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sll_pkg::POS_BITS-1:0]       position,
  input  logic [sll_pkg::IN_VALUE_BITS-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [sll_pkg::FIELD_BITS-1:0]     slot,
  output logic [sll_pkg::FIELD_BITS-1:0]     predecessor
);

  import sll_pkg::*;

  logic     res_valid;
  logic     res_ready;
  result_t  res;

  assign res_ready = !out_valid || !out_stall;

  sll_ctrl #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .position  (position),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      slot        <= res.slot;
      predecessor <= res.pred;
    end
  end

endmodule

// File: dv/sll_insert_predict_check.sv
// Watches both channels of the linked list insert block, predicts each result and compares it.
`timescale 1ns / 1ps
module sll_insert_predict_check #(
  parameter int SLOTS = sll_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [sll_pkg::POS_BITS-1:0]      position,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [1:0]                        status,
  input  logic [sll_pkg::FIELD_BITS-1:0]    slot,
  input  logic [sll_pkg::FIELD_BITS-1:0]    predecessor,
  output int                                inserts_due,
  output int                                errors
);

  import sll_pkg::*;

  localparam logic [FIELD_BITS-1:0] HEAD_SLOT = FIELD_BITS'(SLOTS - 1);

  logic [FIELD_BITS-1:0] link_mem [SLOTS];
  logic [LEN_BITS-1:0]   occupancy;
  result_t               pending_inserts [$];
  int                    mismatches = 0;

  // Checks the position and the free list, pops a free slot, walks pos-1 links from the head and splices it in.
  function automatic result_t predict_insert(logic [POS_BITS-1:0] pos);
    result_t               r;
    logic [FIELD_BITS-1:0] fresh;
    logic [FIELD_BITS-1:0] cursor;
    int                    step;
    r.status = ST_RANGE;
    r.slot   = '0;
    r.pred   = '0;
    if (pos == '0 || int'(pos) > int'(occupancy) + 1) return r;
    fresh = link_mem[0];
    if (fresh == '0) begin
      r.status = ST_FULL;
      return r;
    end
    link_mem[0] = link_mem[fresh];
    cursor = HEAD_SLOT;
    for (step = 1; step < int'(pos); step++) cursor = link_mem[cursor];
    link_mem[fresh]  = link_mem[cursor];
    link_mem[cursor] = fresh;
    occupancy = occupancy + 1'b1;
    r.status = ST_OK;
    r.slot   = fresh;
    r.pred   = cursor;
    return r;
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) link_mem[i] = FIELD_BITS'(i + 1);
      link_mem[SLOTS-2] = '0;
      link_mem[SLOTS-1] = '0;
      occupancy = '0;
      pending_inserts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_inserts.size() == 0) begin
          note_failure($sformatf("unexpected result beat: status %0d slot %0d pred %0d",
                                 status, slot, predecessor));
        end else begin
          want = pending_inserts.pop_front();
          if (status !== want.status || slot !== want.slot || predecessor !== want.pred)
            note_failure($sformatf(
              "result mismatch: exp status %0d slot %0d pred %0d, got status %0d slot %0d pred %0d",
              want.status, want.slot, want.pred, status, slot, predecessor));
        end
      end
      if (in_valid && !in_stall) pending_inserts.push_back(predict_insert(position));
    end
    inserts_due <= pending_inserts.size();
    errors      <= mismatches;
  end

endmodule

// File: dv/static_linked_list_insert_top_tb.sv
// Testbench top for the linked list insert block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module static_linked_list_insert_top_tb;
  import sll_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int RANDOM_BEATS = 550;
  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int RX_HOLD      = 400;
  localparam int DIR_BEATS    = 14;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [POS_BITS-1:0]      position;
  logic [IN_VALUE_BITS-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic [FIELD_BITS-1:0]    slot;
  logic [FIELD_BITS-1:0]    predecessor;

  int inserts_due;
  int errors;
  int cycles = 0;
  int fill;
  int rx_hold_req;
  bit idle_on;

  logic [POS_BITS-1:0] dir_pos [DIR_BEATS] =
    '{10'd0, 10'd2, 10'd1023, 10'd1, 10'd2, 10'd1, 10'd2, 10'd5, 10'd7, 10'd3, 10'd1,
      10'd0, 10'd512, 10'd8};
  logic [IN_VALUE_BITS-1:0] dir_val [DIR_BEATS] =
    '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA,
      16'h5555, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF, 16'h0F0F, 16'hF0F0};

  static_linked_list_insert_top #(.SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot       (slot),
    .predecessor(predecessor)
  );

  sll_insert_predict_check #(.SLOTS(SLOTS)) insert_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot       (slot),
    .predecessor(predecessor),
    .inserts_due(inserts_due),
    .errors     (errors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("static_linked_list_insert_top regression: fail");
      $finish;
    end
  end

  // Result side: random stalls plus a long hold-off on request.
  initial begin
    int hold_left;
    int hold_taken;
    out_stall  = 1'b0;
    hold_left  = 0;
    hold_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_taken != rx_hold_req) begin
        hold_taken = rx_hold_req;
        hold_left  = RX_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 24);
      end
    end
  end

  task automatic send_beat(logic [POS_BITS-1:0] pos, logic [IN_VALUE_BITS-1:0] val);
    while (idle_on && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (pos != '0 && int'(pos) <= fill + 1 && fill < SLOTS - 2) fill++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (inserts_due != 0);
  endtask

  function automatic logic [IN_VALUE_BITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return IN_VALUE_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [POS_BITS-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return POS_BITS'($urandom_range(0, 1023));
    if (r < 30) return POS_BITS'(1);
    if (r < 50) return POS_BITS'(fill + 1);
    return POS_BITS'($urandom_range(1, fill + 1));
  endfunction

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    position    = '0;
    value       = '0;
    fill        = 0;
    rx_hold_req = 0;
    idle_on     = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_BEATS; i++) send_beat(dir_pos[i], dir_val[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 100) rx_hold_req++;
      if (i == 200) idle_on = 1'b0;
      if (i == 300) idle_on = 1'b1;
      if (i == 400) wait_drained();
      send_beat(pick_position(), pick_value());
    end
    wait_drained();

    // boundary positions at both ends of the list, an invalid zero position and random beats
    send_beat(POS_BITS'(1), pick_value());
    send_beat(POS_BITS'(fill + 1), pick_value());
    send_beat('0, pick_value());
    for (int i = 0; i < 12; i++) send_beat(pick_position(), pick_value());

    wait_drained();
    repeat (SLOTS + 64) @(posedge clk);
    if (errors == 0)
      $display("static_linked_list_insert_top regression: pass");
    else
      $display("static_linked_list_insert_top regression: fail");
    $finish;
  end

endmodule
